/* rtl/core/hcb_pkg.sv */
`timescale 1ns / 1ps
package hcb_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam int RunW  = 6;
  localparam int ValW  = 16;
  localparam int CntW  = 32;
  localparam int CodeW = 64;
  localparam int LenW  = 7;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [5:0]        symbol_run;
    logic signed [15:0] symbol_value;
    logic [7:0]        entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         entries_used;
    logic [5:0]         entry_run;
    logic signed [15:0] entry_value;
    logic [31:0]        entry_count;
    logic [63:0]        code_bits;
    logic [6:0]         code_length;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_BST, S_BINIT, S_SCAN, S_MRG1, S_MRG2,
    S_PRD, S_PWL, S_PWR, S_RD1, S_RD2, S_RESP
  } state_e;

endpackage

/* rtl/core/hcb_stream_if.sv */
`timescale 1ns / 1ps
interface hcb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/hcb_ram.sv */
`timescale 1ns / 1ps
module hcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/huffman_codebook_builder.sv */
// channel | dir | payload | accepted when
// req_i   | in  | req_t   | valid && ready
// rsp_o   | out | rsp_t   | valid && ready
// one request at a time; read addresses the tables, then captures the entry; add scans the stored entries
// build: init copies counts into leaf nodes, each merge scans for the two lightest, then paths per inner node
// everything runs through single-write, registered-read memories
// rst_ni clears the state, the entry count, the code flag and the valid flags only
// a finished response waits in the output register while the next request is taken
`timescale 1ns / 1ps
module huffman_codebook_builder #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  hcb_stream_if.sink   req_i,
  hcb_stream_if.source rsp_o
);
  import hcb_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int NODES = 2 * TABLE_ENTRIES - 1;
  localparam int NW    = $clog2(NODES);
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int WW    = CntW + AW;
  localparam int SW    = RunW + ValW + CntW;
  localparam int NDW   = 2 * NW + WW;
  localparam int PW    = CodeW + LenW;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_CODE_BITS);
  localparam logic [LenW-1:0] SatLen = LenW'(MAX_CODE_BITS + 1);

  state_e state_q, state_d;
  logic [CW-1:0] total_q, total_d;
  logic cval_q, cval_d, ovalid_q, ovalid_d, rv_q, rv_d, v2_q, v2_d;
  req_t req_q, req_d;
  rsp_t pend_q, pend_d, rsp_q, rsp_d;
  logic [CW-1:0] i_q, i_d, hs_q, hs_d;
  logic [AW-1:0] pos1_q, pos1_d, pos2_q, pos2_d, m1_q, m1_d, m2_q, m2_d;
  logic [NW-1:0] node2_q, node2_d, a_q, a_d, b_q, b_d, last_q, last_d;
  logic [NW-1:0] next_q, next_d, k_q, k_d, rn_q, rn_d;
  logic [WW-1:0] w1_q, w1_d, w2_q, w2_d;
  logic have1_q, have1_d, have2_q, have2_d, tl_q, tl_d;
  logic [CodeW-1:0] pc_q, pc_d;
  logic [LenW-1:0] pd_q, pd_d;

  logic sym_we, node_we, work_we, path_we;
  logic [AW-1:0] sym_waddr, sym_raddr, work_waddr, work_raddr;
  logic [NW-1:0] node_waddr, node_raddr, path_waddr, path_raddr;
  logic [SW-1:0] sym_wdata, sym_rdata;
  logic [NDW-1:0] node_wdata, node_rdata;
  logic [NW-1:0] work_wdata, work_rdata;
  logic [PW-1:0] path_wdata, path_rdata;

  logic [CntW-1:0] cnt;
  logic [WW-1:0] c;
  logic [NW-1:0] lc, rc;
  logic [CodeW-1:0] pcode;
  logic [LenW-1:0] pdep, dn;
  logic hit, l_leaf, r_leaf, in_range;

  hcb_ram #(.Width(SW), .Depth(TABLE_ENTRIES)) u_sym (
    .clk_i, .we_i(sym_we), .waddr_i(sym_waddr), .wdata_i(sym_wdata),
    .raddr_i(sym_raddr), .rdata_o(sym_rdata));
  hcb_ram #(.Width(NDW), .Depth(NODES)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata));
  hcb_ram #(.Width(NW), .Depth(TABLE_ENTRIES)) u_work (
    .clk_i, .we_i(work_we), .waddr_i(work_waddr), .wdata_i(work_wdata),
    .raddr_i(work_raddr), .rdata_o(work_rdata));
  hcb_ram #(.Width(PW), .Depth(NODES)) u_path (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .raddr_i(path_raddr), .rdata_o(path_rdata));

  assign cnt   = sym_rdata[CntW-1:0];
  assign c     = node_rdata[WW-1:0];
  assign rc    = node_rdata[WW+NW-1:WW];
  assign lc    = node_rdata[WW+2*NW-1:WW+NW];
  assign pcode = path_rdata[PW-1:LenW];
  assign pdep  = path_rdata[LenW-1:0];
  assign dn    = (pdep >= SatLen) ? SatLen : pdep + LenW'(1);
  assign hit   = (sym_rdata[SW-1:SW-RunW] == req_q.symbol_run)
              && (sym_rdata[CntW+ValW-1:CntW] == $unsigned(req_q.symbol_value));
  assign l_leaf = {{(32-NW){1'b0}}, lc} < {{(32-CW){1'b0}}, total_q};
  assign r_leaf = {{(32-NW){1'b0}}, rn_q} < {{(32-CW){1'b0}}, total_q};
  assign in_range = {24'd0, req_q.entry_index} < {{(32-CW){1'b0}}, total_q};

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = ovalid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d = state_q; total_d = total_q; cval_d = cval_q;
    ovalid_d = ovalid_q && !rsp_o.ready;
    rv_d = 1'b0; v2_d = 1'b0;
    req_d = req_q; pend_d = pend_q; rsp_d = rsp_q;
    i_d = i_q; hs_d = hs_q; pos1_d = pos1_q; pos2_d = pos2_q;
    m1_d = m1_q; m2_d = m2_q; node2_d = node2_q; a_d = a_q; b_d = b_q;
    last_d = last_q; next_d = next_q; k_d = k_q; rn_d = rn_q;
    w1_d = w1_q; w2_d = w2_q; have1_d = have1_q; have2_d = have2_q;
    tl_d = tl_q; pc_d = pc_q; pd_d = pd_q;
    sym_we = 1'b0; sym_waddr = pos1_q; sym_wdata = sym_rdata;
    sym_raddr = i_q[AW-1:0];
    node_we = 1'b0; node_waddr = next_q; node_wdata = '0; node_raddr = k_q;
    work_we = 1'b0; work_waddr = i_q[AW-1:0]; work_wdata = NW'(i_q);
    work_raddr = i_q[AW-1:0];
    path_we = 1'b0; path_waddr = lc; path_wdata = '0; path_raddr = k_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d = req_i.payload;
          pend_d = '0;
          i_d = '0;
          unique case (req_i.payload.req_type)
            REQ_ADD:   state_d = S_ADD;
            REQ_BUILD: state_d = S_BST;
            REQ_READ:  state_d = S_RD1;
            default: begin
              pend_d.status = ST_BAD;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_ADD: begin
        if (rv_q && hit) begin
          sym_we = 1'b1;
          sym_waddr = pos1_q;
          sym_wdata = {sym_rdata[SW-1:CntW], (cnt == '1) ? cnt : cnt + CntW'(1)};
          cval_d = 1'b0;
          state_d = S_RESP;
        end else if (i_q == total_q) begin
          if (total_q == CW'(TABLE_ENTRIES)) begin
            pend_d.status = ST_FULL;
          end else begin
            sym_we = 1'b1;
            sym_waddr = total_q[AW-1:0];
            sym_wdata = {req_q.symbol_run, $unsigned(req_q.symbol_value), CntW'(1)};
            total_d = total_q + CW'(1);
            cval_d = 1'b0;
          end
          state_d = S_RESP;
        end else begin
          pos1_d = i_q[AW-1:0];
          rv_d = 1'b1;
          i_d = i_q + CW'(1);
        end
      end
      S_BST: begin
        cval_d = 1'b0;
        if (total_q == '0) begin
          state_d = S_RESP;
        end else if (total_q == CW'(1)) begin
          path_we = 1'b1;
          path_waddr = '0;
          path_wdata = {{CodeW{1'b0}}, LenW'(1)};
          cval_d = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_BINIT;
        end
      end
      S_BINIT: begin
        if (rv_q) begin
          node_we = 1'b1;
          node_waddr = NW'(pos1_q);
          node_wdata = {{(2*NW){1'b0}}, WW'(cnt)};
        end
        if (i_q != total_q) begin
          work_we = 1'b1;
          pos1_d = i_q[AW-1:0];
          rv_d = 1'b1;
          i_d = i_q + CW'(1);
        end else if (!rv_q) begin
          hs_d = total_q;
          next_d = NW'(total_q);
          i_d = '0;
          have1_d = 1'b0;
          have2_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (i_q != hs_q) begin
          pos1_d = i_q[AW-1:0];
          rv_d = 1'b1;
          i_d = i_q + CW'(1);
        end
        if (rv_q) begin
          node_raddr = work_rdata;
          v2_d = 1'b1;
          pos2_d = pos1_q;
          node2_d = work_rdata;
          if (CW'(pos1_q) + CW'(1) == hs_q) begin
            last_d = work_rdata;
          end
        end
        if (v2_q) begin
          if (!have1_q || c < w1_q) begin
            w2_d = w1_q; m2_d = m1_q; b_d = a_q; have2_d = have1_q;
            w1_d = c; m1_d = pos2_q; a_d = node2_q; have1_d = 1'b1;
          end else if (!have2_q || c < w2_q) begin
            w2_d = c; m2_d = pos2_q; b_d = node2_q; have2_d = 1'b1;
          end
        end
        if (i_q == hs_q && !rv_q && !v2_q) begin
          state_d = S_MRG1;
        end
      end
      S_MRG1: begin
        node_we = 1'b1;
        node_waddr = next_q;
        node_wdata = {a_q, b_q, w1_q + w2_q};
        work_we = 1'b1;
        work_waddr = m1_q;
        work_wdata = next_q;
        state_d = S_MRG2;
      end
      S_MRG2: begin
        work_we = 1'b1;
        work_waddr = m2_q;
        work_wdata = (CW'(m1_q) + CW'(1) == hs_q) ? next_q : last_q;
        hs_d = hs_q - CW'(1);
        next_d = next_q + NW'(1);
        if (hs_q == CW'(2)) begin
          path_we = 1'b1;
          path_waddr = next_q;
          path_wdata = '0;
          k_d = next_q;
          tl_d = 1'b0;
          state_d = S_PRD;
        end else begin
          i_d = '0;
          have1_d = 1'b0;
          have2_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_PRD: state_d = S_PWL;
      S_PWL: begin
        path_we = 1'b1;
        path_waddr = lc;
        path_wdata = {pcode[CodeW-2:0], 1'b0, dn};
        if (l_leaf && dn > MaxLen) begin
          tl_d = 1'b1;
        end
        rn_d = rc;
        pc_d = {pcode[CodeW-2:0], 1'b1};
        pd_d = dn;
        state_d = S_PWR;
      end
      S_PWR: begin
        path_we = 1'b1;
        path_waddr = rn_q;
        path_wdata = {pc_q, pd_q};
        if (r_leaf && pd_q > MaxLen) begin
          tl_d = 1'b1;
        end
        if (k_q == NW'(total_q)) begin
          pend_d.status = tl_d ? ST_LONG : ST_OK;
          cval_d = !tl_d;
          state_d = S_RESP;
        end else begin
          k_d = k_q - NW'(1);
          state_d = S_PRD;
        end
      end
      S_RD1: begin
        sym_raddr = AW'(req_q.entry_index);
        path_raddr = NW'(req_q.entry_index);
        state_d = S_RD2;
      end
      S_RD2: begin
        if (in_range) begin
          pend_d.entry_run = sym_rdata[SW-1:SW-RunW];
          pend_d.entry_value = $signed(sym_rdata[CntW+ValW-1:CntW]);
          pend_d.entry_count = cnt;
          if (cval_q) begin
            pend_d.code_bits = pcode;
            pend_d.code_length = pdep;
          end
        end else begin
          pend_d.status = ST_BAD;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ovalid_q || rsp_o.ready) begin
          rsp_d = pend_q;
          rsp_d.entries_used = 9'(total_q);
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      cval_q <= 1'b0;
      ovalid_q <= 1'b0;
      rv_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      cval_q <= cval_d;
      ovalid_q <= ovalid_d;
      rv_q <= rv_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; pend_q <= pend_d; rsp_q <= rsp_d;
    i_q <= i_d; hs_q <= hs_d; pos1_q <= pos1_d; pos2_q <= pos2_d;
    m1_q <= m1_d; m2_q <= m2_d; node2_q <= node2_d; a_q <= a_d; b_q <= b_d;
    last_q <= last_d; next_q <= next_d; k_q <= k_d; rn_q <= rn_d;
    w1_q <= w1_d; w2_q <= w2_d; have1_q <= have1_d; have2_q <= have2_d;
    tl_q <= tl_d; pc_q <= pc_d; pd_q <= pd_d;
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(TABLE_ENTRIES)) else $error("entry count overflow");
  a_codes_need_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cval_q |-> total_q != '0) else $error("codes valid with empty table");
  a_scan_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> hs_q >= CW'(2)) else $error("merge scan on short list");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && ovalid_q && !rsp_o.ready) |=> state_q == S_RESP)
    else $error("response overwrote a waiting result");
`endif
endmodule
